### hw/rtl/case_insensitive_substring_search_assert.svh
// Assertion macros for the substring search block.
`ifndef CASE_INSENSITIVE_SUBSTRING_SEARCH_ASSERT_SVH
`define CASE_INSENSITIVE_SUBSTRING_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define CISS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// Next-cycle implication, checked out of reset.
`define CISS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define CISS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CISS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/ciss_pkg.sv
package ciss_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int MAX_TEXT    = 65536;

  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int POS_W  = $clog2(MAX_TEXT);
  localparam int OFF_W  = 16;
  localparam int PAT_W  = 128;

  localparam logic [7:0] END_MARK  = 8'd26;
  localparam logic [7:0] NUL_MARK  = 8'd0;

  // Register indexes (address bits 4:3)
  localparam logic [1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [1:0] REG_PAT_LEN  = 2'd2;

  typedef struct packed {
    logic shift;
    logic active;
  } cell_ctrl_t;

  // Fold A-Z to lower case; leave every other byte alone.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

### hw/rtl/ciss_cell.sv
module ciss_cell
  import ciss_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] byte_in,
  input  logic [7:0] pat_byte,
  output logic [7:0] byte_held,
  output logic       match
);

  // Hold one window byte; on each shift, load it from the previous cell (the text input for cell 0)
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_held <= byte_in;
    end
  end

  // Compare the byte entering this cell against its aligned pattern byte
  assign match = !ctrl.active ||
                 ((pat_byte != NUL_MARK) && (pat_byte != END_MARK) &&
                  (fold_case(pat_byte) == fold_case(byte_in)));

endmodule

### hw/rtl/case_insensitive_substring_search.sv
// Case-insensitive substring search over a byte stream. One text byte is taken
// per clock cycle unless the result channel stalls; the result word (found,
// match_offset) is registered in the cycle after the byte that decides it, and
// a new byte is taken in the same cycle that a waiting result is taken. The
// window is a row of 16 byte cells that shift together, each comparing its
// incoming byte against the pattern byte aligned to it, so all pattern bytes
// are checked at once. A byte of 0 or 26 ends the text, reports a miss if no
// match was given, and rearms the search. Bytes after a match are dropped until
// the end mark. The user must write the pattern registers (bytes 0-7 at 0x00,
// bytes 8-15 at 0x08, length at 0x10) through the APB port only while the
// block is idle; the block does not enforce it. No clearing pass follows reset.
`include "case_insensitive_substring_search_assert.svh"

module case_insensitive_substring_search
  import ciss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  // text channel
  input  logic              text_valid,
  output logic              text_stall,
  input  logic [7:0]        text_char,
  // result channel
  output logic              result_valid,
  input  logic              result_stall,
  output logic              found,
  output logic [OFF_W-1:0]  match_offset
);

  logic [63:0]      pattern_chars_low;
  logic [63:0]      pattern_chars_high;
  logic [4:0]       pattern_length;

  logic [LEN_W-1:0] window_fill;
  logic [LEN_W-1:0] window_fill_next;
  logic [POS_W-1:0] text_position;
  logic [POS_W-1:0] text_position_next;
  logic             search_done;

  logic             accept;
  logic             is_term;
  logic             advance;
  logic [LEN_W-1:0] len_eff;
  logic [PAT_W-1:0] pat_all;
  logic [PAT_W-1:0] pat_rev;
  logic [PAT_W-1:0] pat_aligned;
  logic [7:0]       held [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_match;
  logic             hit;
  logic [POS_W:0]   off_full;
  logic [OFF_W-1:0] off_sat;
  logic             emit;
  logic             emit_found;
  logic [OFF_W-1:0] emit_offset;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT - 1);

  assign pready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_chars_low  <= '0;
      pattern_chars_high <= '0;
      pattern_length     <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:3])
        REG_PAT_LOW:  pattern_chars_low  <= pwdata;
        REG_PAT_HIGH: pattern_chars_high <= pwdata;
        REG_PAT_LEN:  pattern_length     <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[4:3])
      REG_PAT_LOW:  prdata = pattern_chars_low;
      REG_PAT_HIGH: prdata = pattern_chars_high;
      REG_PAT_LEN:  prdata = {59'd0, pattern_length};
      default:      prdata = '0;
    endcase
  end

  // Handshake: take a byte unless a result is waiting and stalled
  assign text_stall = result_valid && result_stall;
  assign accept     = text_valid && !text_stall;
  assign is_term    = (text_char == NUL_MARK) || (text_char == END_MARK);
  assign advance    = accept && !is_term && !search_done;

  // Clamp the pattern length to the window size
  assign len_eff = (pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                           : LEN_W'(pattern_length);

  // Reverse the pattern bytes, then shift so cell k sees byte len-1-k
  assign pat_all = {pattern_chars_high, pattern_chars_low};
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pat_rev[j*8 +: 8] = pat_all[(MAX_PATTERN-1-j)*8 +: 8];
    end
  end
  assign pat_aligned = pat_rev >> {(LEN_W'(MAX_PATTERN) - len_eff), 3'b000};

  // Row of window cells, newest byte entering cell 0
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    cell_ctrl_t ctrl;
    logic [7:0] byte_in;

    assign ctrl.shift  = advance;
    assign ctrl.active = (LEN_W'(k) < len_eff);
    if (k == 0) begin : g_head
      assign byte_in = text_char;
    end else begin : g_body
      assign byte_in = held[k-1];
    end

    ciss_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .byte_in   (byte_in),
      .pat_byte  (pat_aligned[k*8 +: 8]),
      .byte_held (held[k]),
      .match     (cell_match[k])
    );
  end

  // Fill and position after this byte
  assign window_fill_next   = (window_fill < LEN_W'(MAX_PATTERN)) ? window_fill + 1'b1
                                                                  : window_fill;
  assign text_position_next = (text_position < POS_MAX) ? text_position + 1'b1
                                                        : text_position;

  assign hit = (&cell_match) && (window_fill_next >= len_eff);

  // Start offset of the match, clamped at zero and at the field maximum
  assign off_full = ({1'b0, text_position} + 1'b1 >= (POS_W+1)'(len_eff))
                    ? {1'b0, text_position} + 1'b1 - (POS_W+1)'(len_eff)
                    : '0;
  assign off_sat  = (off_full > (POS_W+1)'({OFF_W{1'b1}})) ? {OFF_W{1'b1}}
                                                           : OFF_W'(off_full);

  // Decide the result for this byte
  always_comb begin
    emit        = 1'b0;
    emit_found  = 1'b0;
    emit_offset = '0;
    priority if (accept && is_term) begin
      emit = !search_done;
    end else if (advance && len_eff == '0) begin
      emit       = 1'b1;
      emit_found = 1'b1;
    end else if (advance && hit) begin
      emit        = 1'b1;
      emit_found  = 1'b1;
      emit_offset = off_sat;
    end else begin
      emit = 1'b0;
    end
  end

  // Search state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill   <= '0;
      text_position <= '0;
      search_done   <= 1'b0;
    end else if (accept && is_term) begin
      window_fill   <= '0;
      text_position <= '0;
      search_done   <= 1'b0;
    end else if (advance) begin
      window_fill   <= window_fill_next;
      text_position <= text_position_next;
      search_done   <= emit;
    end
  end

  // Output register: load a new word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found        <= emit_found;
      match_offset <= emit_offset;
    end
  end

  `CISS_ASSERT_IMPLY(a_miss_offset_zero, clk, rst, result_valid && !found, match_offset == '0)
  `CISS_ASSERT_IMPLY(a_stall_only_when_full, clk, rst, text_stall, result_valid)
  `CISS_ASSERT_NEXT(a_term_rearms, clk, rst, accept && is_term, window_fill == '0 && text_position == '0 && !search_done)
  `CISS_ASSERT_NEXT(a_found_sets_done, clk, rst, emit && emit_found, search_done && result_valid && found)

endmodule

### verif/testbench.sv
module testbench;
  import ciss_pkg::*;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] offset;
  } report_t;

  localparam int STALL_LIMIT = 1000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [4:0]        paddr = '0;
  logic [63:0]       pwdata = '0;
  logic [63:0]       prdata;
  logic              pready;
  logic              text_valid = 1'b0;
  logic              text_stall;
  logic [7:0]        text_char = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic              found;
  logic [OFF_W-1:0]  match_offset;

  // pattern registers as the block should hold them
  logic [63:0] pat_low = '0;
  logic [63:0] pat_high = '0;
  logic [4:0]  pat_len = '0;

  // search state as the block should hold it
  logic [7:0] window_bytes [0:MAX_PATTERN-1];
  int         window_count = 0;
  int         text_index = 0;
  bit         report_given = 1'b0;

  report_t expected_reports [$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  int      chars_sent = 0;
  bit      steady = 1'b0;

  case_insensitive_substring_search dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_char    (text_char),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .found        (found),
    .match_offset (match_offset)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] lower_letter(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] pattern_char(input int i);
    if (i < 8) begin
      return pat_low[8*i +: 8];
    end
    if (i < 16) begin
      return pat_high[8*(i-8) +: 8];
    end
    return 8'h00;
  endfunction

  // Advance the search by one text byte and queue the report it causes.
  task automatic predict_char(input logic [7:0] c);
    int      len;
    int      pos;
    int      off;
    bit      hit;
    logic [7:0] pc;
    report_t word;
    if (c == NUL_MARK || c == END_MARK) begin
      if (!report_given) begin
        word.found = 1'b0;
        word.offset = '0;
        expected_reports.push_back(word);
      end
      window_count = 0;
      text_index = 0;
      report_given = 1'b0;
      return;
    end
    if (report_given) begin
      return;
    end
    for (int i = MAX_PATTERN - 1; i > 0; i--) begin
      window_bytes[i] = window_bytes[i-1];
    end
    window_bytes[0] = c;
    if (window_count < MAX_PATTERN) begin
      window_count++;
    end
    pos = text_index;
    if (text_index < MAX_TEXT - 1) begin
      text_index++;
    end
    len = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
    if (len == 0) begin
      report_given = 1'b1;
      word.found = 1'b1;
      word.offset = '0;
      expected_reports.push_back(word);
      return;
    end
    if (window_count < len) begin
      return;
    end
    hit = 1'b1;
    for (int i = 0; i < len; i++) begin
      pc = pattern_char(i);
      if (pc == NUL_MARK || pc == END_MARK ||
          lower_letter(pc) != lower_letter(window_bytes[len-1-i])) begin
        hit = 1'b0;
      end
    end
    if (!hit) begin
      return;
    end
    report_given = 1'b1;
    off = (pos + 1 >= len) ? pos + 1 - len : 0;
    if (off > 65535) begin
      off = 65535;
    end
    word.found = 1'b1;
    word.offset = off[OFF_W-1:0];
    expected_reports.push_back(word);
  endtask

  // Predict on each accepted byte, then check each accepted result word.
  always @(posedge clk) begin : watch_ports
    report_t want;
    if (!rst) begin
      if (text_valid && !text_stall) begin
        predict_char(text_char);
      end
      if (result_valid && !result_stall) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected result word: found=%0d match_offset=%0d", found, match_offset);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            mismatches++;
          end
          if (match_offset !== want.offset) begin
            $error("match_offset: expected %0d, got %0d", want.offset, match_offset);
            mismatches++;
          end
        end
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stall the result channel now and then.
  always @(negedge clk) begin
    result_stall <= !steady && ($urandom_range(0, 99) < 10);
  end

  // Send one text word, with an occasional gap ahead of it.
  task automatic send_char(input logic [7:0] c);
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 10) begin
      text_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    text_valid <= 1'b1;
    text_char <= c;
    do @(posedge clk); while (text_stall);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic [7:0] term);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
    send_char(term);
  endtask

  task automatic text_quiet;
    @(negedge clk);
    text_valid <= 1'b0;
  endtask

  // Wait until every report has arrived and the block has settled.
  task automatic await_idle;
    text_quiet;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PAT_LOW: begin
        pat_low = value;
      end
      REG_PAT_HIGH: begin
        pat_high = value;
      end
      REG_PAT_LEN: begin
        pat_len = value[4:0];
      end
      default: begin
      end
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_pattern(input logic [127:0] bits, input logic [4:0] len);
    await_idle;
    write_reg(REG_PAT_LOW, bits[63:0]);
    write_reg(REG_PAT_HIGH, bits[127:64]);
    write_reg(REG_PAT_LEN, {59'd0, len});
  endtask

  function automatic logic [127:0] pattern_from_string(input string s);
    logic [127:0] bits;
    bits = '0;
    for (int i = 0; i < s.len() && i < 16; i++) begin
      bits[8*i +: 8] = s[i];
    end
    return bits;
  endfunction

  // Mixed case match, miss at either end mark, empty text, drop after a match.
  task automatic test_basics;
    write_pattern(pattern_from_string("aB"), 5'd2);
    send_text("XAbab", NUL_MARK);
    send_text("Q", END_MARK);
    send_text("", NUL_MARK);
  endtask

  // Empty pattern hits on the first byte but not on an empty text.
  task automatic test_empty_pattern;
    write_pattern('0, 5'd0);
    send_text("", NUL_MARK);
    send_text("km", END_MARK);
  endtask

  // All-ones pattern, non-letters near the letter range, end marks inside the pattern.
  task automatic test_pattern_extremes;
    logic [127:0] bits;
    write_pattern('1, 5'd2);
    send_char(8'hFF);
    send_char(8'hFF);
    send_char(END_MARK);
    write_pattern(pattern_from_string("[@"), 5'd2);
    send_text("{`[@", NUL_MARK);
    bits = pattern_from_string("a");
    bits[15:8] = END_MARK;
    write_pattern(bits, 5'd2);
    send_text("aa", NUL_MARK);
    bits[15:8] = NUL_MARK;
    write_pattern(bits, 5'd2);
    send_text("aa", END_MARK);
  endtask

  // Change the pattern inside a text; the window keeps the earlier bytes.
  task automatic test_change_mid_text;
    write_pattern(pattern_from_string("cd"), 5'd2);
    send_char("a");
    send_char("b");
    send_char("c");
    write_pattern(pattern_from_string("BCD"), 5'd3);
    send_text("d", NUL_MARK);
  endtask

  // Run a long text with both sides running flat out.
  task automatic test_long_text;
    write_pattern(pattern_from_string("z"), 5'd1);
    steady = 1'b1;
    repeat (200) send_char("a");
    send_text("Z", NUL_MARK);
    await_idle;
    steady = 1'b0;
  endtask

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      return ($urandom_range(0, 1) == 1) ? (c ^ 8'h20) : c;
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_letter;
    logic [7:0] c;
    c = 8'h61 + 8'($urandom_range(0, 2));
    return flip_case(c);
  endfunction

  function automatic logic [7:0] pick_text_byte;
    logic [7:0] c;
    if ($urandom_range(0, 99) < 85) begin
      return pick_letter();
    end
    c = 8'($urandom_range(1, 255));
    return (c == END_MARK) ? c + 8'd1 : c;
  endfunction

  // Random texts over a small alphabet, often with the pattern planted.
  task automatic test_random_texts;
    int           first;
    int           plen;
    int           used;
    int           n;
    int           plant;
    int           r;
    logic [127:0] bits;
    logic [7:0]   c;
    first = chars_sent;
    plen = 0;
    bits = '0;
    while (chars_sent - first < 1100) begin
      if (plen == 0 || $urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 19);
        plen = (r == 0) ? 0 : (r == 1) ? 16 : (r == 2) ? $urandom_range(17, 31) :
               $urandom_range(1, 5);
        for (int i = 0; i < 16; i++) begin
          bits[8*i +: 8] = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255)) :
                           pick_letter();
        end
        write_pattern(bits, plen[4:0]);
      end
      used = (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
      steady = (chars_sent - first >= 500) && (chars_sent - first < 800);
      n = $urandom_range(0, 30);
      plant = ($urandom_range(0, 1) == 1) ? $urandom_range(0, n) : -1;
      for (int k = 0; k <= n; k++) begin
        if (k == plant) begin
          for (int i = 0; i < used; i++) begin
            c = bits[8*i +: 8];
            if (c == NUL_MARK || c == END_MARK) begin
              c = pick_letter();
            end
            send_char(flip_case(c));
          end
        end
        if (k < n) begin
          send_char(pick_text_byte());
        end
      end
      send_char(($urandom_range(0, 1) == 1) ? END_MARK : NUL_MARK);
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      window_bytes[i] = 8'h00;
    end
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_basics;
    test_empty_pattern;
    test_pattern_extremes;
    test_change_mid_text;
    test_long_text;
    test_random_texts;
    await_idle;
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
